### hw/rtl/refcounted_page_allocator_top_assert.svh
// Assertion macros used by the allocator checker.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Checked only while out of reset.
`define RPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define RPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths
  localparam int PAGE_W     = 15;
  localparam int END_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_OUT_W  = 16;
  localparam int STATUS_W   = 3;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_ADD_REF = 2'd2,
    OP_SPLIT   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NO_PAGE  = 3'd1,
    STS_RANGE    = 3'd2,
    STS_NOT_OWN  = 3'd3,
    STS_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic {
    CFG_FIRST_PAGE = 1'b0,
    CFG_END_PAGE   = 1'b1
  } cfg_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // Port strobes of a single-port memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

### hw/rtl/rpa_count_mem.sv
// Reference count memory with a zeroing sweep after reset.
module rpa_count_mem #(
  parameter int PAGES      = 32768,
  parameter int COUNT_BITS = 16,
  localparam int AW        = (PAGES > 1) ? $clog2(PAGES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpa_pkg::mem_ctl_t     ctl_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [COUNT_BITS-1:0] wdata_i,
  output logic [COUNT_BITS-1:0] rdata_o,
  output logic                  ready_o
);

  logic [COUNT_BITS-1:0] mem_q [PAGES];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  logic                  clr_busy_q, clr_busy_d;

  // Sweep pointer: one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AW'(PAGES - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Storage, registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

### hw/rtl/rpa_stack_mem.sv
// Freed-page stack storage.
module rpa_stack_mem #(
  parameter int PAGES = 32768,
  localparam int AW   = (PAGES > 1) ? $clog2(PAGES) : 1
) (
  input  logic              clk_i,
  input  rpa_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [AW-1:0]     wdata_i,
  output logic [AW-1:0]     rdata_o
);

  logic [AW-1:0] mem_q [PAGES];
  logic [AW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rpa_ctrl.sv
// Request sequencer: issues memory reads, then modifies and writes back.
module rpa_ctrl #(
  parameter int PAGES      = 32768,
  parameter int COUNT_BITS = 16,
  localparam int AW        = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int DW        = $clog2(PAGES + 1),
  localparam int EW        = (DW > rpa_pkg::END_W) ? DW : rpa_pkg::END_W
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       op_i,
  input  logic [rpa_pkg::PAGE_W-1:0]       page_index_i,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // results
  output logic                             done_o,
  output logic [rpa_pkg::STATUS_W-1:0]     status_o,
  output logic [rpa_pkg::PAGE_W-1:0]       alloc_page_o,
  output logic                             page_released_o,
  output logic                             sole_owner_o,
  output logic [rpa_pkg::CNT_OUT_W-1:0]    ref_count_o,
  // count memory
  input  logic                             cnt_ready_i,
  output rpa_pkg::mem_ctl_t                cnt_ctl_o,
  output logic [AW-1:0]                    cnt_addr_o,
  output logic [COUNT_BITS-1:0]            cnt_wdata_o,
  input  logic [COUNT_BITS-1:0]            cnt_rdata_i,
  // stack memory
  output rpa_pkg::mem_ctl_t                stk_ctl_o,
  output logic [AW-1:0]                    stk_addr_o,
  output logic [AW-1:0]                    stk_wdata_o,
  input  logic [AW-1:0]                    stk_rdata_i
);

  rpa_pkg::fsm_e state_q, state_d;

  logic                           exec;
  logic                           accept;
  rpa_pkg::op_e                   op_q;
  logic [AW-1:0]                  page_q;
  logic                           inr_q, inr;
  logic [rpa_pkg::PAGE_W-1:0]     first_q;
  logic [rpa_pkg::END_W-1:0]      end_q;
  logic [DW-1:0]                  depth_q, depth_d;
  logic [DW-1:0]                  fresh_q, fresh_d;
  logic [EW-1:0]                  end_ext, eff_end, pool;

  // result registers
  logic                           done_q;
  rpa_pkg::status_e               status_q, status_d;
  logic [AW-1:0]                  apage_q, apage_d;
  logic                           rel_q, rel_d;
  logic                           sole_q, sole_d;
  logic [COUNT_BITS-1:0]          cnt_q, cnt_d;

  // write-back strobes of the execute cycle
  logic                           cnt_wr, stk_wr;
  logic [AW-1:0]                  cnt_waddr;
  logic [COUNT_BITS-1:0]          cnt_wval;
  logic [COUNT_BITS-1:0]          c;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpa_pkg::FSM_IDLE: begin
        if (accept) state_d = rpa_pkg::FSM_EXEC;
      end
      rpa_pkg::FSM_EXEC: state_d = rpa_pkg::FSM_IDLE;
      default:           state_d = rpa_pkg::FSM_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    exec = 1'b0;
    busy = !cnt_ready_i;
    unique case (state_q)
      rpa_pkg::FSM_IDLE: ;
      rpa_pkg::FSM_EXEC: begin
        exec = 1'b1;
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  // Usable range, clipped to the memory size
  always_comb begin
    end_ext = EW'(end_q);
    eff_end = (end_ext > EW'(PAGES)) ? EW'(PAGES) : end_ext;
    pool    = (eff_end > EW'(first_q)) ? eff_end - EW'(first_q) : '0;
    inr     = (page_index_i >= first_q) && (EW'(page_index_i) < eff_end);
  end

  // Execute: modify what the memories returned
  always_comb begin
    c         = cnt_rdata_i;
    status_d  = rpa_pkg::STS_OK;
    apage_d   = '0;
    rel_d     = 1'b0;
    sole_d    = 1'b0;
    cnt_d     = '0;
    cnt_wr    = 1'b0;
    cnt_waddr = page_q;
    cnt_wval  = '0;
    stk_wr    = 1'b0;
    depth_d   = depth_q;
    fresh_d   = fresh_q;
    if (op_q == rpa_pkg::OP_ALLOC) begin
      if (depth_q != '0) begin
        apage_d = stk_rdata_i;
        depth_d = depth_q - DW'(1);
        cnt_wr  = 1'b1;
      end else if (EW'(fresh_q) < pool) begin
        apage_d = AW'(eff_end - EW'(1) - EW'(fresh_q));
        fresh_d = fresh_q + DW'(1);
        cnt_wr  = 1'b1;
      end else begin
        status_d = rpa_pkg::STS_NO_PAGE;
      end
      if (cnt_wr) begin
        cnt_waddr = apage_d;
        cnt_wval  = COUNT_BITS'(1);
        cnt_d     = COUNT_BITS'(1);
      end
    end else if (!inr_q) begin
      status_d = rpa_pkg::STS_RANGE;
    end else begin
      case (op_q)
        rpa_pkg::OP_FREE: begin
          if (c > COUNT_BITS'(1)) begin
            cnt_d    = c - COUNT_BITS'(1);
            cnt_wval = cnt_d;
            cnt_wr   = 1'b1;
          end else if (c == COUNT_BITS'(1)) begin
            cnt_wr = 1'b1;
            // last reference: back onto the stack unless it is full
            if (depth_q < DW'(PAGES)) begin
              stk_wr  = 1'b1;
              depth_d = depth_q + DW'(1);
              rel_d   = 1'b1;
            end
          end else begin
            status_d = rpa_pkg::STS_NOT_OWN;
          end
        end
        rpa_pkg::OP_ADD_REF: begin
          if (c == '1) begin
            status_d = rpa_pkg::STS_OVERFLOW;
            cnt_d    = c;
          end else begin
            cnt_d    = c + COUNT_BITS'(1);
            cnt_wval = cnt_d;
            cnt_wr   = 1'b1;
          end
        end
        rpa_pkg::OP_SPLIT: begin
          if (c == COUNT_BITS'(1)) begin
            sole_d = 1'b1;
            cnt_d  = c;
          end else if (c > COUNT_BITS'(1)) begin
            cnt_d    = c - COUNT_BITS'(1);
            cnt_wval = cnt_d;
            cnt_wr   = 1'b1;
          end else begin
            status_d = rpa_pkg::STS_NOT_OWN;
          end
        end
        default: ;
      endcase
    end
  end

  // Memory ports: reads at accept, writes during execute
  always_comb begin
    cnt_ctl_o.rd_en = accept && (op_i != rpa_pkg::OP_ALLOC) && inr;
    cnt_ctl_o.wr_en = exec && cnt_wr;
    cnt_addr_o      = exec ? cnt_waddr : AW'(page_index_i);
    cnt_wdata_o     = cnt_wval;
    stk_ctl_o.rd_en = accept && (op_i == rpa_pkg::OP_ALLOC) && (depth_q != '0);
    stk_ctl_o.wr_en = exec && stk_wr;
    stk_addr_o      = exec ? AW'(depth_q) : AW'(depth_q - DW'(1));
    stk_wdata_o     = page_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpa_pkg::FSM_IDLE;
      depth_q <= '0;
      fresh_q <= '0;
      done_q  <= 1'b0;
      first_q <= '0;
      end_q   <= rpa_pkg::END_W'(32768);
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec) begin
        depth_q <= depth_d;
        fresh_q <= fresh_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (rpa_pkg::cfg_e'(cfg_index_i))
          rpa_pkg::CFG_FIRST_PAGE: first_q <= cfg_data_i[rpa_pkg::PAGE_W-1:0];
          rpa_pkg::CFG_END_PAGE:   end_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= rpa_pkg::op_e'(op_i);
      page_q <= AW'(page_index_i);
      inr_q  <= inr;
    end
    if (exec) begin
      status_q <= status_d;
      apage_q  <= apage_d;
      rel_q    <= rel_d;
      sole_q   <= sole_d;
      cnt_q    <= cnt_d;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign alloc_page_o    = rpa_pkg::PAGE_W'(apage_q);
  assign page_released_o = rel_q;
  assign sole_owner_o    = sole_q;
  assign ref_count_o     = rpa_pkg::CNT_OUT_W'(cnt_q);

endmodule

### hw/rtl/refcounted_page_allocator_top.sv
// Channel    Handshake                  Payload
// request    start & !busy              op_i, page_index_i
// result     done_o (one-cycle strobe)  status_o, alloc_page_o, page_released_o,
//                                       sole_owner_o, ref_count_o
// config     cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item is accepted in the idle state, reading the count or stack memory;
// the execute state writes back and loads the result, shown with done_o once
// idle again, when the next item can already be accepted. The single-port
// count memory holds new items off during write-back. After reset, busy stays
// high while the count memory is swept to zero; config writes are taken
// throughout (cfg_ready_o is always high). The result side cannot stall.
module refcounted_page_allocator_top #(
  parameter int PAGES      = 32768,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op_i,
  input  logic [rpa_pkg::PAGE_W-1:0]     page_index_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic [rpa_pkg::STATUS_W-1:0]   status_o,
  output logic [rpa_pkg::PAGE_W-1:0]     alloc_page_o,
  output logic                           page_released_o,
  output logic                           sole_owner_o,
  output logic [rpa_pkg::CNT_OUT_W-1:0]  ref_count_o
);

  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;

  rpa_pkg::mem_ctl_t     cnt_ctl, stk_ctl;
  logic [AW-1:0]         cnt_addr, stk_addr, stk_wdata, stk_rdata;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  cnt_ready;

  rpa_ctrl #(
    .PAGES      (PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .page_index_i    (page_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .alloc_page_o    (alloc_page_o),
    .page_released_o (page_released_o),
    .sole_owner_o    (sole_owner_o),
    .ref_count_o     (ref_count_o),
    .cnt_ready_i     (cnt_ready),
    .cnt_ctl_o       (cnt_ctl),
    .cnt_addr_o      (cnt_addr),
    .cnt_wdata_o     (cnt_wdata),
    .cnt_rdata_i     (cnt_rdata),
    .stk_ctl_o       (stk_ctl),
    .stk_addr_o      (stk_addr),
    .stk_wdata_o     (stk_wdata),
    .stk_rdata_i     (stk_rdata)
  );

  rpa_count_mem #(
    .PAGES      (PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cnt_ctl),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata),
    .ready_o (cnt_ready)
  );

  rpa_stack_mem #(
    .PAGES (PAGES)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .ctl_i   (stk_ctl),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

endmodule

### hw/rtl/rpa_checker.sv
`include "refcounted_page_allocator_top_assert.svh"

// Port-level checks of the allocator.
module rpa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     op_i,
  input logic [rpa_pkg::PAGE_W-1:0]     page_index_i,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic                           cfg_index_i,
  input logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           done_o,
  input logic [rpa_pkg::STATUS_W-1:0]   status_o,
  input logic [rpa_pkg::PAGE_W-1:0]     alloc_page_o,
  input logic                           page_released_o,
  input logic                           sole_owner_o,
  input logic [rpa_pkg::CNT_OUT_W-1:0]  ref_count_o
);

  // every accepted item is answered by done_o after the execute state
  `RPA_ASSERT(a_result_follows, (start && !busy) |-> ##2 done_o, "item without result")

  // no result without an accepted item ahead of it
  `RPA_ASSERT(a_no_spurious, done_o |-> $past(start && !busy, 2), "result without item")

  // the execute cycle blocks a new item
  `RPA_ASSERT(a_busy_exec, (start && !busy) |=> busy, "item accepted during execute")

  // a good allocate leaves exactly one reference
  `RPA_ASSERT(a_alloc_one,
    (done_o && status_o == rpa_pkg::STS_OK && $past(op_i, 2) == rpa_pkg::OP_ALLOC)
      |-> (ref_count_o == rpa_pkg::CNT_OUT_W'(1)), "allocate count not one")

  // a released page is a clean free
  `RPA_ASSERT(a_release_ok,
    (done_o && page_released_o) |-> (status_o == rpa_pkg::STS_OK && !sole_owner_o
      && ref_count_o == '0), "release with bad status")

endmodule

bind refcounted_page_allocator_top rpa_checker u_rpa_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rpa_pkg::*;

  localparam int PAGES_N      = 32768;
  localparam int COUNT_BITS   = 16;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int OWNED_KEEP   = 48;

  // One result item as the block reports it
  typedef struct packed {
    status_e              status;
    logic [PAGE_W-1:0]    page;
    logic                 released;
    logic                 sole;
    logic [CNT_OUT_W-1:0] count;
  } alloc_result_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic [1:0]            op_i         = OP_ALLOC;
  logic [PAGE_W-1:0]     page_index_i = '0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_index_i  = CFG_FIRST_PAGE;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  busy;
  logic                  cfg_ready_o;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [PAGE_W-1:0]     alloc_page_o;
  logic                  page_released_o;
  logic                  sole_owner_o;
  logic [CNT_OUT_W-1:0]  ref_count_o;

  // Allocator state as the testbench sees it
  logic [COUNT_BITS-1:0] page_refs [PAGES_N];
  logic [PAGE_W-1:0]     freed_pages [$];
  int unsigned           fresh_taken_cnt;
  int unsigned           range_first;
  int unsigned           range_end;

  alloc_result_t         expected_results [$];
  logic [PAGE_W-1:0]     owned_pages [$];
  int unsigned           sender_idle_pct;
  int unsigned           mismatch_cnt;

  refcounted_page_allocator_top #(
    .PAGES     (PAGES_N),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .page_index_i   (page_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .alloc_page_o   (alloc_page_o),
    .page_released_o(page_released_o),
    .sole_owner_o   (sole_owner_o),
    .ref_count_o    (ref_count_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  function automatic void note_failure(string msg);
    if (mismatch_cnt < 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endfunction

  // Apply one request to the allocator state, return the result it must give
  function automatic alloc_result_t predict_request(op_e op, logic [PAGE_W-1:0] pg);
    alloc_result_t     r;
    int unsigned       lim;
    int unsigned       pool;
    int unsigned       c;
    logic              got;
    logic [PAGE_W-1:0] pg_out;
    r   = '0;
    lim = (range_end > PAGES_N) ? PAGES_N : range_end;
    if (op == OP_ALLOC) begin
      pool = (lim > range_first) ? lim - range_first : 0;
      got  = 1'b1;
      if (freed_pages.size() > 0) begin
        pg_out = freed_pages.pop_back();
      end else if (fresh_taken_cnt < pool) begin
        pg_out = PAGE_W'(lim - 1 - fresh_taken_cnt);
        fresh_taken_cnt++;
      end else begin
        got      = 1'b0;
        r.status = STS_NO_PAGE;
      end
      if (got) begin
        page_refs[pg_out] = COUNT_BITS'(1);
        r.page            = pg_out;
        r.count           = CNT_OUT_W'(1);
      end
    end else if (pg < range_first || pg >= lim) begin
      r.status = STS_RANGE;
    end else begin
      c = 32'(page_refs[pg]);
      case (op)
        OP_FREE: begin
          if (c > 1) begin
            r.count       = CNT_OUT_W'(c - 1);
            page_refs[pg] = COUNT_BITS'(c - 1);
          end else if (c == 1) begin
            page_refs[pg] = '0;
            // a full stack drops the push
            if (freed_pages.size() < PAGES_N) begin
              freed_pages.push_back(pg);
              r.released = 1'b1;
            end
          end else begin
            r.status = STS_NOT_OWN;
          end
        end
        OP_ADD_REF: begin
          if (c >= COUNT_MAX) begin
            r.status = STS_OVERFLOW;
            r.count  = CNT_OUT_W'(c);
          end else begin
            r.count       = CNT_OUT_W'(c + 1);
            page_refs[pg] = COUNT_BITS'(c + 1);
          end
        end
        default: begin
          if (c == 1) begin
            r.sole  = 1'b1;
            r.count = CNT_OUT_W'(1);
          end else if (c > 1) begin
            r.count       = CNT_OUT_W'(c - 1);
            page_refs[pg] = COUNT_BITS'(c - 1);
          end else begin
            r.status = STS_NOT_OWN;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Send one request item; start stays high when the next one follows at once
  task automatic issue_request(op_e op, logic [PAGE_W-1:0] pg);
    alloc_result_t res;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < sender_idle_pct) @(posedge clk_i);
    end
    start        <= 1'b1;
    op_i         <= op;
    page_index_i <= pg;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = predict_request(op, pg);
    expected_results.push_back(res);
    if (op == OP_ALLOC && res.status == STS_OK) begin
      owned_pages.push_back(res.page);
      if (owned_pages.size() > OWNED_KEEP) void'(owned_pages.pop_front());
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Both range registers, written back to back while the block is idle
  task automatic configure_range(int unsigned lo, int unsigned hi);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FIRST_PAGE;
    cfg_data_i  <= CFG_DATA_W'(lo);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    range_first = lo & 32'h7FFF;
    cfg_index_i <= CFG_END_PAGE;
    cfg_data_i  <= CFG_DATA_W'(hi);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    range_end = hi & 32'hFFFF;
    cfg_valid_i <= 1'b0;
  endtask

  // Reset range: fresh pages from the top, stack reuse, double free, split
  task automatic test_alloc_free_basics();
    issue_request(OP_ALLOC, '0);
    issue_request(OP_ALLOC, '1);
    issue_request(OP_ADD_REF, 15'd32767);
    issue_request(OP_SPLIT, 15'd32767);
    issue_request(OP_SPLIT, 15'd32767);
    issue_request(OP_FREE, 15'd32767);
    issue_request(OP_FREE, 15'd32767);
    issue_request(OP_SPLIT, 15'd32767);
    issue_request(OP_ALLOC, 15'h5555);
    // add reference to a free page, then free and reuse it
    issue_request(OP_ADD_REF, 15'd0);
    issue_request(OP_FREE, 15'd0);
    issue_request(OP_ALLOC, '0);
  endtask

  // Range edges, empty and single-page ranges, range shrunk after use
  task automatic test_range_limits();
    configure_range(100, 116);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_FREE, 15'd99);
    issue_request(OP_ADD_REF, 15'd116);
    issue_request(OP_SPLIT, 15'd113);
    issue_request(OP_FREE, 15'd113);
    issue_request(OP_ALLOC, '0);
    configure_range(32767, 1);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_ADD_REF, 15'd32767);
    configure_range(32767, 32768);
    issue_request(OP_ADD_REF, 15'd32767);
    issue_request(OP_SPLIT, 15'd32767);
    configure_range(0, 1);
    issue_request(OP_SPLIT, 15'd0);
    issue_request(OP_ALLOC, '0);
  endtask

  // Mostly requests on pages already handed out, the rest on random pages
  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                     int unsigned lo, int unsigned hi);
    op_e               op;
    logic [PAGE_W-1:0] pg;
    int unsigned       r;
    configure_range(lo, hi);
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_ALLOC;
      else if (r < 55) op = OP_FREE;
      else if (r < 75) op = OP_ADD_REF;
      else op = OP_SPLIT;
      if ($urandom_range(0, 9) < 8 && owned_pages.size() > 0) begin
        pg = owned_pages[$urandom_range(0, owned_pages.size() - 1)];
      end else begin
        pg = PAGE_W'($urandom_range(0, PAGES_N - 1));
      end
      issue_request(op, pg);
    end
  endtask

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        note_failure("result item with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || alloc_page_o !== want.page ||
            page_released_o !== want.released || sole_owner_o !== want.sole ||
            ref_count_o !== want.count) begin
          note_failure($sformatf({"exp sts=%0d page=%0d rel=%0b sole=%0b cnt=%0d, ",
                                  "got sts=%0d page=%0d rel=%0b sole=%0b cnt=%0d"},
                                 want.status, want.page, want.released, want.sole,
                                 want.count, status_o, alloc_page_o, page_released_o,
                                 sole_owner_o, ref_count_o));
        end
      end
    end
  end

  initial begin
    foreach (page_refs[i]) page_refs[i] = '0;
    fresh_taken_cnt = 0;
    range_first     = 0;
    range_end       = PAGES_N;
    mismatch_cnt    = 0;
    sender_idle_pct = 13;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_alloc_free_basics();
    test_range_limits();
    test_random_traffic(370, 13, 0, PAGES_N);
    test_random_traffic(370, 77, $urandom_range(1, 2000), $urandom_range(24000, 32767));
    test_random_traffic(370, 0, $urandom_range(0, 30000), PAGES_N);
    drain_results();

    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d result items never arrived", expected_results.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit: several times the slowest expected run, reset sweep included
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_count_mem.sv
hw/rtl/rpa_stack_mem.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/refcounted_page_allocator_top.sv
hw/rtl/rpa_checker.sv
dv/tb.sv
